FILE: src/cfse_pkg.sv
// cfse_pkg: shared types and constants for the CPU frequency scale estimator.
// Used by cfse_ctrl, cfse_dp and cpu_freq_scale_estimator; depends on nothing.
package cfse_pkg;

	// event command codes
	localparam logic [2:0] CMD_TICK       = 3'd0;
	localparam logic [2:0] CMD_WAKEUP     = 3'd1;
	localparam logic [2:0] CMD_IDLE_ENTER = 3'd2;
	localparam logic [2:0] CMD_IDLE_EXIT  = 3'd3;
	localparam logic [2:0] CMD_ONLINE     = 3'd4;

	// configuration register indexes
	localparam logic CFG_MAX_FREQ   = 1'b0;
	localparam logic CFG_MIN_SAMPLE = 1'b1;

	// register reset values
	localparam logic [23:0] MAX_FREQ_RST   = 24'd3302400;
	localparam logic [31:0] MIN_SAMPLE_RST = 32'd100000;

	// kHz per cycle-per-ns
	localparam logic [19:0] KHZ_PER_CPNS = 20'd1000000;

	// divider sizing: 84-bit dividend for the frequency, 34-bit for the scale
	localparam int NUM_W       = 84;
	localparam int CNT_W       = 7;
	localparam int FREQ_STEPS  = 84;
	localparam int SCALE_STEPS = 34;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CHECK,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIV_LOAD,
		ST_DIV_FREQ,
		ST_FREQ,
		ST_DIV_SCALE,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic clr_tick;
		logic mul_lo;
		logic mul_hi;
		logic div_load;
		logic div_step;
		logic fin;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic upd;
		logic acc_ready;
		logic div_done;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: src/cfse_ctrl.sv
// cfse_ctrl: sequencing state machine of the frequency scale estimator.
// Depends on cfse_pkg; drives cfse_dp through command and status structs.
module cfse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cfse_pkg::dp_sts_t sts,
	output cfse_pkg::dp_cmd_t cmd
);

	cfse_pkg::state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// advance through sample, multiply, two divisions and emit
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			cfse_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = cfse_pkg::ST_EXEC;
				end
			end
			cfse_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.upd ? cfse_pkg::ST_CHECK : cfse_pkg::ST_IDLE;
			end
			cfse_pkg::ST_CHECK: begin
				if (sts.acc_ready) begin
					state_d = cfse_pkg::ST_MUL_LO;
				end else begin
					cmd.clr_tick = 1'b1;
					state_d      = cfse_pkg::ST_IDLE;
				end
			end
			cfse_pkg::ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = cfse_pkg::ST_MUL_HI;
			end
			cfse_pkg::ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = cfse_pkg::ST_DIV_LOAD;
			end
			cfse_pkg::ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = cfse_pkg::ST_DIV_FREQ;
			end
			cfse_pkg::ST_DIV_FREQ: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = cfse_pkg::ST_FREQ;
				end
			end
			cfse_pkg::ST_FREQ: begin
				cmd.fin = 1'b1;
				state_d = cfse_pkg::ST_DIV_SCALE;
			end
			cfse_pkg::ST_DIV_SCALE: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = cfse_pkg::ST_EMIT;
				end
			end
			cfse_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = cfse_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cfse_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: src/cfse_dp.sv
// cfse_dp: sample and accumulator state, shared multiplier, radix-2 divider
// and output register of the frequency scale estimator. Depends on cfse_pkg.
module cfse_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_wdata,
	input  logic [2:0]        cmd_in,
	input  logic [63:0]       cycle_sample,
	input  logic [63:0]       time_sample,
	input  logic              blocked,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [10:0]       freq_scale,
	output logic [23:0]       freq_khz,
	input  cfse_pkg::dp_cmd_t cmd,
	output cfse_pkg::dp_sts_t sts
);

	localparam int NW = cfse_pkg::NUM_W;

	logic [23:0]           max_q;
	logic [31:0]           min_q;
	logic [2:0]            cmd_q;
	logic [63:0]           cyc_q;
	logic [63:0]           t_q;
	logic                  blk_q;
	logic                  dt_ge_q;
	logic [63:0]           last_c_q;
	logic [63:0]           last_t_q;
	logic [63:0]           acc_c_q;
	logic [63:0]           acc_t_q;
	logic [51:0]           prod_lo_q;
	logic [51:0]           prod_hi_q;
	logic [NW-1:0]         num_q;
	logic [63:0]           rem_q;
	logic [63:0]           dvs_q;
	logic [cfse_pkg::CNT_W-1:0] cnt_q;
	logic [23:0]           freq_q;
	logic                  out_valid_q;
	logic [10:0]           freq_scale_q;
	logic [23:0]           freq_khz_q;

	logic [31:0]           mul_a;
	logic [51:0]           mul_p;
	logic [64:0]           rem_sh;
	logic                  q_bit;
	logic [64:0]           rem_sub;
	logic                  freq_sat;
	logic [23:0]           freq_d;
	logic                  upd;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= cfse_pkg::MAX_FREQ_RST;
			min_q <= cfse_pkg::MIN_SAMPLE_RST;
		end else if (cfg_we) begin
			if (cfg_index == cfse_pkg::CFG_MAX_FREQ) begin
				max_q <= cfg_wdata[23:0];
			end else begin
				min_q <= cfg_wdata;
			end
		end
	end

	// capture request and pre-compare the time since the last sample
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= cmd_in;
			cyc_q   <= cycle_sample;
			t_q     <= time_sample;
			blk_q   <= blocked;
			dt_ge_q <= (time_sample - last_t_q) >= {32'd0, min_q};
		end
	end

	assign upd = (cmd_q == cfse_pkg::CMD_TICK) ||
		((cmd_q == cfse_pkg::CMD_WAKEUP) && !blk_q);

	// sample and accumulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_c_q <= '0;
			last_t_q <= '0;
			acc_c_q  <= '0;
			acc_t_q  <= '0;
		end else if (cmd.exec) begin
			case (cmd_q)
				cfse_pkg::CMD_TICK, cfse_pkg::CMD_WAKEUP: begin
					if (upd && dt_ge_q) begin
						acc_c_q  <= acc_c_q + (cyc_q - last_c_q);
						acc_t_q  <= acc_t_q + (t_q - last_t_q);
						last_c_q <= cyc_q;
						last_t_q <= t_q;
					end
				end
				cfse_pkg::CMD_IDLE_ENTER: begin
					if (!blk_q) begin
						acc_c_q  <= acc_c_q + (cyc_q - last_c_q);
						acc_t_q  <= acc_t_q + (t_q - last_t_q);
						last_c_q <= cyc_q;
						last_t_q <= t_q;
					end
				end
				cfse_pkg::CMD_IDLE_EXIT: begin
					if (blk_q) begin
						acc_c_q <= '0;
						acc_t_q <= '0;
					end else begin
						last_c_q <= cyc_q;
						last_t_q <= t_q;
					end
				end
				cfse_pkg::CMD_ONLINE: begin
					last_c_q <= cyc_q;
					last_t_q <= t_q;
					acc_c_q  <= '0;
					acc_t_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if ((cmd.clr_tick && (cmd_q == cfse_pkg::CMD_TICK)) || cmd.emit) begin
			acc_c_q <= '0;
			acc_t_q <= '0;
		end
	end

	// form acc_cycles * 1e6 as two 32x20 partial products
	assign mul_a = cmd.mul_hi ? acc_c_q[63:32] : acc_c_q[31:0];
	assign mul_p = mul_a * cfse_pkg::KHZ_PER_CPNS;

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			prod_lo_q <= mul_p;
		end
		if (cmd.mul_hi) begin
			prod_hi_q <= mul_p;
		end
	end

	// one restoring divider step: shift in the next dividend bit
	assign rem_sh  = {rem_q, num_q[NW-1]};
	assign q_bit   = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	// clamp the frequency quotient to the maximum
	assign freq_sat = (|num_q[NW-1:24]) || (num_q[23:0] > max_q);
	assign freq_d   = freq_sat ? max_q : num_q[23:0];

	// shared divider: load, iterate, then reload for the scale division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_load) begin
			cnt_q <= cfse_pkg::CNT_W'(cfse_pkg::FREQ_STEPS - 1);
		end else if (cmd.fin) begin
			cnt_q <= cfse_pkg::CNT_W'(cfse_pkg::SCALE_STEPS - 1);
		end else if (cmd.div_step && (cnt_q != '0)) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q <= {prod_hi_q, 32'd0} + {32'd0, prod_lo_q};
			rem_q <= '0;
			dvs_q <= acc_t_q;
		end else if (cmd.fin) begin
			num_q  <= {freq_d, 10'd0, 50'd0};
			rem_q  <= '0;
			dvs_q  <= {40'd0, max_q};
			freq_q <= freq_d;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NW-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[63:0] : rem_sh[63:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			freq_scale_q <= (max_q == '0) ? 11'd0 : num_q[10:0];
			freq_khz_q   <= freq_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign freq_scale = freq_scale_q;
	assign freq_khz   = freq_khz_q;

	assign sts.upd       = upd;
	assign sts.acc_ready = acc_t_q >= {32'd0, min_q};
	assign sts.div_done  = cnt_q == '0;
	assign sts.out_free  = !out_valid_q || out_ready;

	// an emitted request leaves a valid result and cleared accumulators
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q && (acc_t_q == '0) && (acc_c_q == '0))
		else $error("emit did not load output or clear accumulators");

	// the scale never exceeds full capacity
	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> freq_scale_q <= 11'd1024)
		else $error("freq_scale above 1024");

	// the divider stops stepping once its count runs out
	a_div_stop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && (cnt_q == '0) |=> !cmd.div_step)
		else $error("divider stepped past its last bit");

	// the emitted frequency respects the clamp
	a_freq_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> freq_khz_q <= max_q)
		else $error("freq_khz above max_freq_khz");

endmodule

FILE: src/cpu_freq_scale_estimator.sv
// Per-CPU frequency-invariance scale estimator, top level.
// Channels: input request (in_valid/in_ready) carries cmd, cycle_sample,
// time_sample and blocked; output request (out_valid/out_ready) carries
// freq_scale and freq_khz. Registers max_freq_khz (index 0) and
// min_sample_ns (index 1) are written through cfg_we/cfg_index/cfg_wdata.
// One request is worked on at a time. A request that yields no result
// passes the exec state (and for tick and unblocked wakeup the check
// state) before in_ready rises again. A request that yields a result
// is sampled, multiplied as two 32x20 partial products, divided in 84
// steps of the shared radix-2 divider for the frequency, clamped, and
// divided in 34 steps for the scale, then put in the output register.
// A held result does not stop the next request from being taken; only
// a second result waits in the emit state until the first is taken.
// Reset (arst_n low) clears samples and accumulators and restores the
// register defaults 3302400 kHz and 100000 ns.
// Depends on cfse_pkg, cfse_ctrl and cfse_dp.
module cpu_freq_scale_estimator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [63:0] cycle_sample,
	input  logic [63:0] time_sample,
	input  logic        blocked,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [10:0] freq_scale,
	output logic [23:0] freq_khz
);

	cfse_pkg::dp_cmd_t dp_cmd;
	cfse_pkg::dp_sts_t dp_sts;

	cfse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	cfse_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cmd_in       (cmd),
		.cycle_sample (cycle_sample),
		.time_sample  (time_sample),
		.blocked      (blocked),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.freq_scale   (freq_scale),
		.freq_khz     (freq_khz),
		.cmd          (dp_cmd),
		.sts          (dp_sts)
	);

endmodule

FILE: dv/cfse_checker.sv
`timescale 1ns / 100ps
// cfse_checker: watches the register port and both request channels of
// cpu_freq_scale_estimator, predicts each frequency result and compares it.
// Depends on cfse_pkg.
module cfse_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [63:0] cycle_sample,
	input  logic [63:0] time_sample,
	input  logic        blocked,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [10:0] freq_scale,
	input  logic [23:0] freq_khz,
	output int          fail_count,
	output int          results_owed
);

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [10:0] scale;
		logic [23:0] khz;
	} freq_res_t;

	// shadow registers and estimator state
	logic [23:0] max_khz;
	logic [31:0] min_ns;
	logic [63:0] last_cyc;
	logic [63:0] last_ns;
	logic [63:0] acc_cyc;
	logic [63:0] acc_ns;
	freq_res_t   freq_q[$];
	int          mismatches = 0;

	assign fail_count = mismatches;

	task automatic flag_error(input string what, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (mismatches < MAX_REPORTS)
			$display("%0t freq result: %s expected %0d got %0d", $time, what, want_v, got_v);
		mismatches++;
	endtask

	// frequency from the accumulators, clamped, and its capacity scale
	function automatic freq_res_t measure_freq();
		logic [127:0] quo;
		logic [23:0]  khz;
		freq_res_t    res;
		if (acc_ns == '0) begin
			khz = max_khz;
		end else begin
			quo = (128'(acc_cyc) * 128'(cfse_pkg::KHZ_PER_CPNS)) / 128'(acc_ns);
			khz = (quo > 128'(max_khz)) ? max_khz : quo[23:0];
		end
		res.khz = khz;
		// scale is 1024 * khz / max
		res.scale = (max_khz == '0) ? '0 : 11'((35'(khz) << 10) / 35'(max_khz));
		return res;
	endfunction

	task automatic sample_acc(input logic [63:0] cyc, input logic [63:0] t);
		acc_cyc = acc_cyc + (cyc - last_cyc);
		acc_ns = acc_ns + (t - last_ns);
		last_cyc = cyc;
		last_ns = t;
	endtask

	// tick and wakeup: sample if enough time passed, then emit or (tick) clear
	task automatic scale_update(input logic is_tick, input logic [63:0] cyc,
			input logic [63:0] t);
		if (t - last_ns >= 64'(min_ns))
			sample_acc(cyc, t);
		if (acc_ns >= 64'(min_ns)) begin
			freq_q.push_back(measure_freq());
			acc_cyc = '0;
			acc_ns = '0;
		end else if (is_tick) begin
			acc_cyc = '0;
			acc_ns = '0;
		end
	endtask

	task automatic predict_event(input logic [2:0] c, input logic [63:0] cyc,
			input logic [63:0] t, input logic blk);
		case (c)
			cfse_pkg::CMD_TICK: begin
				scale_update(1'b1, cyc, t);
			end
			cfse_pkg::CMD_WAKEUP: begin
				if (!blk)
					scale_update(1'b0, cyc, t);
			end
			cfse_pkg::CMD_IDLE_ENTER: begin
				if (!blk)
					sample_acc(cyc, t);
			end
			cfse_pkg::CMD_IDLE_EXIT: begin
				if (blk) begin
					acc_cyc = '0;
					acc_ns = '0;
				end else begin
					last_cyc = cyc;
					last_ns = t;
				end
			end
			cfse_pkg::CMD_ONLINE: begin
				last_cyc = cyc;
				last_ns = t;
				acc_cyc = '0;
				acc_ns = '0;
			end
			default: begin
			end
		endcase
	endtask

	// track writes, compare returned results, then predict the new request
	always @(posedge clk or negedge arst_n) begin
		freq_res_t want;
		if (!arst_n) begin
			max_khz = cfse_pkg::MAX_FREQ_RST;
			min_ns = cfse_pkg::MIN_SAMPLE_RST;
			last_cyc = '0;
			last_ns = '0;
			acc_cyc = '0;
			acc_ns = '0;
			freq_q.delete();
			results_owed <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == cfse_pkg::CFG_MAX_FREQ)
					max_khz = cfg_wdata[23:0];
				else
					min_ns = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (freq_q.size() == 0) begin
					flag_error("no result pending, freq_khz", '0, 64'(freq_khz));
				end else begin
					want = freq_q.pop_front();
					if (want.scale !== freq_scale)
						flag_error("freq_scale", 64'(want.scale), 64'(freq_scale));
					if (want.khz !== freq_khz)
						flag_error("freq_khz", 64'(want.khz), 64'(freq_khz));
				end
			end
			if (in_valid && in_ready)
				predict_event(cmd, cycle_sample, time_sample, blocked);
			results_owed <= freq_q.size();
		end
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// testbench: drives event requests and register writes into
// cpu_freq_scale_estimator and gives the verdict from cfse_checker.
// Depends on cfse_pkg, cpu_freq_scale_estimator and cfse_checker.
module testbench;

	localparam int PHASE_EVENTS = 290;
	localparam int IDLE_SPLIT = 590;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_CYCLES = 600;
	localparam logic [2:0] CMD_FIRST_UNUSED = cfse_pkg::CMD_ONLINE + 3'd1;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  cmd;
	logic [63:0] cycle_sample;
	logic [63:0] time_sample;
	logic        blocked;
	logic        out_valid;
	logic        out_ready;
	logic [10:0] freq_scale;
	logic [23:0] freq_khz;
	int          fail_count;
	int          results_owed;

	// stimulus state: idle rates, pressure request, running counters, config
	int          send_idle_pct;
	int          recv_idle_pct;
	int          sent_total;
	logic        hold_req;
	logic [63:0] stim_cyc;
	logic [63:0] stim_ns;
	logic [23:0] cur_max;
	logic [31:0] cur_min;

	cpu_freq_scale_estimator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.cycle_sample (cycle_sample),
		.time_sample  (time_sample),
		.blocked      (blocked),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.freq_scale   (freq_scale),
		.freq_khz     (freq_khz)
	);

	cfse_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.cycle_sample (cycle_sample),
		.time_sample  (time_sample),
		.blocked      (blocked),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.freq_scale   (freq_scale),
		.freq_khz     (freq_khz),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// offer one request after a random gap and hold it until taken
	task automatic send_event(input logic [2:0] c, input logic [63:0] cyc,
			input logic [63:0] t, input logic blk);
		int gap;
		gap = 0;
		if (sent_total < IDLE_SPLIT) begin
			send_idle_pct = 7;
			recv_idle_pct = 82;
		end else if (sent_total < 2 * IDLE_SPLIT) begin
			send_idle_pct = 82;
			recv_idle_pct = 7;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		cycle_sample <= cyc;
		time_sample <= t;
		blocked <= blk;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_total++;
	endtask

	// drop valid and hold until every predicted result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	task automatic write_regs(input logic [23:0] max_v, input logic [31:0] min_v);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= cfse_pkg::CFG_MAX_FREQ;
		cfg_wdata <= {8'd0, max_v};
		@(posedge clk);
		cfg_index <= cfse_pkg::CFG_MIN_SAMPLE;
		cfg_wdata <= min_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_max = max_v;
		cur_min = min_v;
	endtask

	// advance time and cycles at a random frequency, then send an event
	task automatic send_plausible();
		logic [63:0] dt;
		logic [63:0] f;
		logic [2:0]  c;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 60)
			dt = 64'(cur_min) + (64'(cur_min) * $urandom_range(1000)) / 1000;
		else if (pick < 90)
			dt = (64'(cur_min) * $urandom_range(999)) / 1000;
		else
			dt = 64'($urandom_range(3));
		// mostly below the maximum, some above to hit the clamp
		f = (64'(cur_max) * $urandom_range(1500)) / 1000;
		stim_ns = stim_ns + dt;
		stim_cyc = stim_cyc + (dt * f) / 1000000;
		pick = $urandom_range(99);
		if (pick < 40)
			c = cfse_pkg::CMD_TICK;
		else if (pick < 65)
			c = cfse_pkg::CMD_WAKEUP;
		else if (pick < 80)
			c = cfse_pkg::CMD_IDLE_ENTER;
		else if (pick < 92)
			c = cfse_pkg::CMD_IDLE_EXIT;
		else
			c = cfse_pkg::CMD_ONLINE;
		send_event(c, stim_cyc, stim_ns, $urandom_range(99) < 15);
	endtask

	// fully random event; sometimes rebase the running counters on it
	task automatic send_noise();
		logic [63:0] cyc;
		logic [63:0] t;
		cyc = {$urandom, $urandom};
		t = {$urandom, $urandom};
		send_event(3'($urandom_range(7)), cyc, t, 1'($urandom_range(1)));
		if ($urandom_range(1) == 1) begin
			stim_cyc = cyc;
			stim_ns = t;
		end
	endtask

	task automatic random_phase(input int hold_at, input int pause_at);
		for (int i = 0; i < PHASE_EVENTS; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			if (i == pause_at)
				wait_drained();
			if ($urandom_range(99) < 8)
				send_noise();
			else
				send_plausible();
		end
	endtask

	initial begin
		in_valid = 1'b0;
		cmd = cfse_pkg::CMD_TICK;
		cycle_sample = '0;
		time_sample = '0;
		blocked = 1'b0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = cfse_pkg::CFG_MAX_FREQ;
		cfg_wdata = '0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sent_total = 0;
		cur_max = cfse_pkg::MAX_FREQ_RST;
		cur_min = cfse_pkg::MIN_SAMPLE_RST;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed events on the reset settings
		send_event(cfse_pkg::CMD_ONLINE, 64'd0, 64'd0, 1'b0);
		// full speed over exactly the minimum time; blocked does not matter to a tick
		send_event(cfse_pkg::CMD_TICK, 64'd330240, 64'd100000, 1'b1);
		// short tick: no sample, accumulators cleared
		send_event(cfse_pkg::CMD_TICK, 64'd400000, 64'd150000, 1'b0);
		send_event(cfse_pkg::CMD_WAKEUP, 64'd999999, 64'd900000, 1'b1);
		// twice the maximum: clamped
		send_event(cfse_pkg::CMD_WAKEUP, 64'd1651200, 64'd300000, 1'b0);
		send_event(cfse_pkg::CMD_IDLE_ENTER, 64'd1700000, 64'd310000, 1'b1);
		send_event(cfse_pkg::CMD_IDLE_ENTER, 64'd1716000, 64'd320000, 1'b0);
		// wakeup too early: keeps the accumulators
		send_event(cfse_pkg::CMD_WAKEUP, 64'd1730000, 64'd330000, 1'b0);
		send_event(cfse_pkg::CMD_IDLE_EXIT, 64'd1800000, 64'd400000, 1'b0);
		send_event(cfse_pkg::CMD_WAKEUP, 64'd1900000, 64'd500000, 1'b0);
		send_event(cfse_pkg::CMD_IDLE_EXIT, 64'd0, 64'd0, 1'b1);
		send_event(cfse_pkg::CMD_IDLE_ENTER, 64'd2000000, 64'd550000, 1'b0);
		send_event(cfse_pkg::CMD_IDLE_EXIT, '1, '1, 1'b1);
		// unused command codes are dropped
		for (int k = 0; k < 3; k++)
			send_event(CMD_FIRST_UNUSED + 3'(k), '1, '1, 1'(k));
		// quotient too large for 64 bits, then zero cycles
		send_event(cfse_pkg::CMD_ONLINE, 64'd0, 64'd0, 1'b1);
		send_event(cfse_pkg::CMD_TICK, '1, 64'd100000, 1'b0);
		send_event(cfse_pkg::CMD_TICK, '1, 64'd200000, 1'b0);
		// both counters wrap
		send_event(cfse_pkg::CMD_ONLINE, '1, '1, 1'b0);
		send_event(cfse_pkg::CMD_TICK, 64'd1000, 64'd99999, 1'b0);
		stim_cyc = 64'd1000;
		stim_ns = 64'd99999;

		// random phases over several settings, extremes first
		random_phase(40, -1);
		write_regs(24'hFF_FFFF, 32'd1);
		random_phase(-1, -1);
		write_regs(24'd1, 32'hFFFF_FFFF);
		random_phase(-1, 150);
		write_regs(24'd2265600, 32'($urandom_range(1000000, 1000)));
		random_phase(-1, -1);
		write_regs(24'($urandom_range(24'hFF_FFFF, 1)), 32'($urandom_range(5000000, 1)));
		random_phase(-1, -1);
		write_regs(cfse_pkg::MAX_FREQ_RST, cfse_pkg::MIN_SAMPLE_RST);
		random_phase(-1, -1);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
